// ===== sv/bfcs_pkg.sv =====
// Shared constants, types and codes of the exhaustive CNF satisfiability checker.
`default_nettype none

package bfcs_pkg;

  localparam int unsigned LitW        = 20;
  localparam int unsigned NumVarsW    = 5;
  localparam int unsigned VerdictW    = 2;
  localparam int unsigned MaxVarsDef  = 20;
  localparam int unsigned MaxClausDef = 128;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [NumVarsW-1:0] NumVarsRst = NumVarsW'(20);

  typedef enum logic [VerdictW-1:0] {
    VerdictSat      = 2'd0,
    VerdictUnsat    = 2'd1,
    VerdictOverflow = 2'd2
  } verdict_e;

  // One classified clause on its way from the front end to the search engine.
  typedef struct packed {
    logic [LitW-1:0] pos;
    logic [LitW-1:0] neg;
    logic            store;
    logic            last;
    logic            ovf;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/bfcs_if.sv =====
// Valid/ready channel interfaces for clauses, verdicts and the configuration write.
`default_nettype none

interface bfcs_clause_if;
  import bfcs_pkg::*;
  logic            valid;
  logic            ready;
  logic [LitW-1:0] pos_literals;
  logic [LitW-1:0] neg_literals;
  logic            last_clause;
  modport source (output valid, pos_literals, neg_literals, last_clause, input ready);
  modport sink   (input valid, pos_literals, neg_literals, last_clause, output ready);
endinterface

interface bfcs_verdict_if;
  import bfcs_pkg::*;
  logic                valid;
  logic                ready;
  logic [VerdictW-1:0] verdict;
  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

interface bfcs_cfg_if;
  import bfcs_pkg::*;
  logic                valid;
  logic                ready;
  logic [NumVarsW-1:0] num_vars;
  modport source (output valid, num_vars, input ready);
  modport sink   (input valid, num_vars, output ready);
endinterface

`default_nettype wire

// ===== sv/bfcs_front.sv =====
// Front end: takes clauses, tracks the clause count of the formula and marks overflow.
`default_nettype none

module bfcs_front #(
  parameter int unsigned MAX_CLAUSES = bfcs_pkg::MaxClausDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  bfcs_clause_if.sink        clause_ch,
  input  wire logic          q_full_i,
  output logic               push_o,
  output bfcs_pkg::cmd_t     cmd_o
);
  import bfcs_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_CLAUSES + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic            store;

  assign clause_ch.ready = !q_full_i;
  assign push_o          = clause_ch.valid && !q_full_i;
  assign store           = (cnt_q < CntW'(MAX_CLAUSES));

  always_comb begin
    cmd_o.pos   = clause_ch.pos_literals;
    cmd_o.neg   = clause_ch.neg_literals;
    cmd_o.store = store;
    cmd_o.last  = clause_ch.last_clause;
    cmd_o.ovf   = ovf_q || !store;
  end

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (push_o) begin
      if (clause_ch.last_clause) begin
        // The formula ends here; the next transfer opens a new one.
        cnt_d = '0;
        ovf_d = 1'b0;
      end else begin
        cnt_d = cnt_q + CntW'(store);
        ovf_d = ovf_q || !store;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bfcs_cmd_queue.sv =====
// Short queue of classified clauses between the front end and the search engine.
`default_nettype none

module bfcs_cmd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  bfcs_pkg::cmd_t     cmd_i,
  output logic               full_o,
  output logic               valid_o,
  output bfcs_pkg::cmd_t     cmd_o,
  input  wire logic          pop_i
);
  import bfcs_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bfcs_back.sv =====
// Back end: clause store and the exhaustive search over all assignments.
`default_nettype none

module bfcs_back #(
  parameter int unsigned MAX_VARS    = bfcs_pkg::MaxVarsDef,
  parameter int unsigned MAX_CLAUSES = bfcs_pkg::MaxClausDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  input  bfcs_pkg::cmd_t                     cmd_i,
  output logic                               cmd_pop_o,
  input  wire logic [bfcs_pkg::NumVarsW-1:0] num_vars_i,
  bfcs_verdict_if.source                     verdict_ch
);
  import bfcs_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_CLAUSES + 1);
  localparam int unsigned AddrW = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StEmit
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     wp_q, wp_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     k_q, k_d;
  logic [MAX_VARS-1:0] a_q, a_d;
  logic [MAX_VARS-1:0] lim_q, lim_d;
  logic                vld_q, vld_d;
  logic                lastk_q, lastk_d;
  verdict_e            verdict_q, verdict_d;
  logic                out_vld_q, out_vld_d;
  logic [VerdictW-1:0] out_verdict_q, out_verdict_d;

  logic [2*LitW-1:0]   mem [MAX_CLAUSES];
  logic [2*LitW-1:0]   rd_q;

  logic [LitW-1:0]     asg;
  logic [LitW-1:0]     rd_pos, rd_neg;
  logic [NumVarsW-1:0] n_sat;
  logic [MAX_VARS-1:0] lim_n;
  logic                holds, fail, at_lim, done_sat, done_unsat;
  logic [CntW-1:0]     iss;
  logic                issue, wr_en;

  // Assignment bits above the enumerated range stay false.
  for (genvar i = 0; i < LitW; i++) begin : g_asg
    if (i < MAX_VARS) begin : g_used
      assign asg[i] = a_q[i];
    end else begin : g_zero
      assign asg[i] = 1'b0;
    end
  end

  assign n_sat = (num_vars_i > NumVarsW'(MAX_VARS)) ? NumVarsW'(MAX_VARS) : num_vars_i;

  always_comb begin
    for (int i = 0; i < MAX_VARS; i++) begin
      lim_n[i] = (NumVarsW'(i) < n_sat);
    end
  end

  assign rd_pos     = rd_q[LitW-1:0];
  assign rd_neg     = rd_q[2*LitW-1:LitW];
  assign holds      = (|(rd_neg & ~asg)) || (|(rd_pos & asg));
  assign fail       = vld_q && !holds;
  assign at_lim     = (a_q == lim_q);
  assign done_sat   = vld_q && holds && lastk_q;
  assign done_unsat = fail && at_lim;

  // A failing clause restarts the fetch at the first clause for the next assignment.
  assign iss   = fail ? '0 : k_q;
  assign issue = (state_q == StSearch) && !done_sat && !done_unsat && (iss < cnt_q);

  assign cmd_pop_o = (state_q == StIdle) && cmd_valid_i;
  assign wr_en     = cmd_pop_o && cmd_i.store;

  assign verdict_ch.valid   = out_vld_q;
  assign verdict_ch.verdict = out_verdict_q;

  always_comb begin
    state_d       = state_q;
    wp_d          = wp_q;
    cnt_d         = cnt_q;
    k_d           = k_q;
    a_d           = a_q;
    lim_d         = lim_q;
    vld_d         = 1'b0;
    lastk_d       = lastk_q;
    verdict_d     = verdict_q;
    out_vld_d     = out_vld_q && !verdict_ch.ready;
    out_verdict_d = out_verdict_q;

    case (state_q)
      StIdle: begin
        if (cmd_pop_o) begin
          wp_d = wp_q + CntW'(cmd_i.store);
          if (cmd_i.last) begin
            wp_d = '0;
            if (cmd_i.ovf) begin
              verdict_d = VerdictOverflow;
              state_d   = StEmit;
            end else begin
              cnt_d   = wp_q + CntW'(cmd_i.store);
              k_d     = '0;
              a_d     = '0;
              lim_d   = lim_n;
              state_d = StSearch;
            end
          end
        end
      end
      StSearch: begin
        if (done_sat) begin
          verdict_d = VerdictSat;
          state_d   = StEmit;
        end else if (done_unsat) begin
          verdict_d = VerdictUnsat;
          state_d   = StEmit;
        end else if (fail) begin
          a_d = a_q + 1'b1;
        end
        if (issue) begin
          vld_d   = 1'b1;
          k_d     = iss + 1'b1;
          lastk_d = (iss == cnt_q - 1'b1);
        end
      end
      StEmit: begin
        if (!out_vld_q || verdict_ch.ready) begin
          out_vld_d     = 1'b1;
          out_verdict_d = verdict_q;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      wp_q          <= '0;
      cnt_q         <= '0;
      k_q           <= '0;
      a_q           <= '0;
      lim_q         <= '0;
      vld_q         <= 1'b0;
      lastk_q       <= 1'b0;
      verdict_q     <= VerdictSat;
      out_vld_q     <= 1'b0;
      out_verdict_q <= '0;
    end else begin
      state_q       <= state_d;
      wp_q          <= wp_d;
      cnt_q         <= cnt_d;
      k_q           <= k_d;
      a_q           <= a_d;
      lim_q         <= lim_d;
      vld_q         <= vld_d;
      lastk_q       <= lastk_d;
      verdict_q     <= verdict_d;
      out_vld_q     <= out_vld_d;
      out_verdict_q <= out_verdict_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wp_q[AddrW-1:0]] <= {cmd_i.neg, cmd_i.pos};
    end
    if (issue) begin
      rd_q <= mem[iss[AddrW-1:0]];
    end
  end

endmodule

`default_nettype wire

// ===== sv/brute_force_cnf_sat_checker.sv =====
// Clauses load one per cycle while the two-entry queue has room; a queued last clause
// starts a search over all 2^n assignments, n = min(num_vars, MAX_VARS), one clause per cycle
// from the clause store. An assignment ends at its first failing clause; the search stops at
// the first satisfying assignment or when the last one fails. An overflowed formula skips the
// search when its last clause leaves the queue; verdicts go via StEmit to the output register.
// Reset is asynchronous and active low; it clears counts, queue and output, not the store.
`default_nettype none

module brute_force_cnf_sat_checker #(
  parameter int unsigned MAX_VARS    = bfcs_pkg::MaxVarsDef,
  parameter int unsigned MAX_CLAUSES = bfcs_pkg::MaxClausDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  bfcs_clause_if.sink    clause_ch,
  bfcs_verdict_if.source verdict_ch,
  bfcs_cfg_if.sink       cfg_ch
);
  import bfcs_pkg::*;

  logic [NumVarsW-1:0] num_vars_q;
  logic                push, q_full, q_valid, q_pop;
  cmd_t                push_cmd, q_cmd;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vars_q <= NumVarsRst;
    end else if (cfg_ch.valid) begin
      num_vars_q <= cfg_ch.num_vars;
    end
  end

  bfcs_front #(
    .MAX_CLAUSES (MAX_CLAUSES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clause_ch (clause_ch),
    .q_full_i  (q_full),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  bfcs_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (q_pop)
  );

  bfcs_back #(
    .MAX_VARS    (MAX_VARS),
    .MAX_CLAUSES (MAX_CLAUSES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .num_vars_i  (num_vars_q),
    .verdict_ch  (verdict_ch)
  );

endmodule

`default_nettype wire

// ===== sv/bfcs_checker.sv =====
// Port-level checks of the CNF satisfiability checker and their binding to the top level.
`default_nettype none

module bfcs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [1:0] verdict_i,
  input wire logic       cfg_ready_i
);
  import bfcs_pkg::*;

  // A verdict waiting for its transfer keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(verdict_i))
    else $error("verdict changed or dropped while stalled");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (verdict_i == VerdictSat) || (verdict_i == VerdictUnsat) ||
                    (verdict_i == VerdictOverflow))
    else $error("verdict carries an unused code");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration channel not ready");

  a_reset_out: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("verdict valid right after reset");

endmodule

bind brute_force_cnf_sat_checker bfcs_checker u_bfcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (verdict_ch.valid),
  .out_ready_i (verdict_ch.ready),
  .verdict_i   (verdict_ch.verdict),
  .cfg_ready_i (cfg_ch.ready)
);

`default_nettype wire
